// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker in hw/rtl/sacl_checker.sv.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

// ===== hw/rtl/sacl_pkg.sv =====
// Package for the set associative cache lookup block.
// Holds payload structs, register indexes and the controller state type.
`timescale 1ns / 1ps
package sacl_pkg;
   localparam int CNT_W = 32;
   localparam int TIME_W = 48;
   localparam logic [15:0] LFSR_SEED = 16'hACE1;

   typedef struct packed {
      logic [31:0] address;
      logic        req_type;
   } req_type_type;

   typedef struct packed {
      logic              hit;
      logic [1:0]        way;
      logic              mem_read;
      logic              mem_write;
      logic [CNT_W-1:0]  read_count;
      logic [CNT_W-1:0]  write_count;
      logic [CNT_W-1:0]  read_hit_count;
      logic [CNT_W-1:0]  write_hit_count;
      logic [CNT_W-1:0]  mem_read_count;
      logic [CNT_W-1:0]  mem_write_count;
      logic [TIME_W-1:0] total_time;
   } rsp_type_type;

   typedef enum logic [2:0] {
      REG_WRITE_BACK  = 3'd0,
      REG_USE_LRU     = 3'd1,
      REG_OFFSET_BITS = 3'd2,
      REG_INDEX_BITS  = 3'd3,
      REG_HIT_TIME    = 3'd4,
      REG_MEMORY_TIME = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DECIDE,
      ST_OUT
   } state_type;
endpackage

// ===== hw/rtl/sacl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hw/rtl/set_assoc_cache_lookup.sv =====
// Set associative cache lookup: top level. Uses sacl_pkg and sacl_ram.
// An access (address, read/write kind) is a transfer on req_valid/req_stall, and its
// result is a transfer on rsp_valid/rsp_stall. One access is in flight at a time.
// The selected set row (tags with dirty flags, and use stamps) is read from two
// memories with registered read data. The READ step registers the hit compare and the
// victim search; the DECIDE step picks the way, writes the row back and loads the result
// register. A new access is accepted only after the last one has left its DECIDE step;
// the memory read and the read-modify-write of one row keep accesses from overlapping.
// The result register holds while rsp_stall is high. The next access is still accepted
// and read, then waits in its decide step until the held result is taken.
// Reset clears the valid bits, which live in flip-flops, the stamp and the counters,
// and loads the random generator with its seed. The memories need no clearing
// because only the contents of valid ways are used. Configuration is written over
// csr_valid/csr_ready; the user must write it only while idle, which the block itself
// does not enforce. csr_ready is always high.
// Counters saturate: six at 2^32-1, total time at 2^48-1.
`timescale 1ns / 1ps
module set_assoc_cache_lookup #(
   parameter int SETS = 64,
   parameter int WAYS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sacl_pkg::req_type_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sacl_pkg::rsp_type_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data
);
   localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TW = 33;

   logic        write_back_ff, use_lru_ff;
   logic [4:0]  offset_bits_ff;
   logic [2:0]  index_bits_ff;
   logic [15:0] hit_time_ff, memory_time_ff;

   sacl_pkg::state_type state_ff, state_in;
   logic [31:0] tag_ff;
   logic        is_wr_ff;
   logic [SW-1:0] set_ff;
   logic [SETS-1:0][WAYS-1:0] valid_ff;
   logic [31:0] gstamp_ff;
   logic [15:0] lfsr_ff;
   logic [sacl_pkg::CNT_W-1:0] cnt_ff [6];
   logic [sacl_pkg::TIME_W-1:0] time_ff;
   sacl_pkg::rsp_type_type rsp_ff;
   logic        rsp_valid_ff;
   logic        dec_fire;

   logic [WAYS*TW-1:0] tags_rd, tags_wr;
   logic [WAYS*32-1:0] stamps_rd, stamps_wr;
   logic row_we;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_back_ff <= 1'b0;
         use_lru_ff <= 1'b1;
         offset_bits_ff <= 5'd6;
         index_bits_ff <= 3'd6;
         hit_time_ff <= 16'd1;
         memory_time_ff <= 16'd100;
      end else if (csr_valid) begin
         unique case (csr_index)
            sacl_pkg::REG_WRITE_BACK:  write_back_ff <= csr_data[0];
            sacl_pkg::REG_USE_LRU:     use_lru_ff <= csr_data[0];
            sacl_pkg::REG_OFFSET_BITS: offset_bits_ff <= csr_data[4:0];
            sacl_pkg::REG_INDEX_BITS:  index_bits_ff <= csr_data[2:0];
            sacl_pkg::REG_HIT_TIME:    hit_time_ff <= csr_data;
            sacl_pkg::REG_MEMORY_TIME: memory_time_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Address split.
   logic [31:0] idx_raw, idx_mask, tag_calc;
   logic [5:0]  sh_sum;
   logic [SW-1:0] set_calc;
   always_comb begin
      idx_mask = (32'd1 << index_bits_ff) - 32'd1;
      idx_raw = (req_data.address >> offset_bits_ff) & idx_mask;
      sh_sum = {1'b0, offset_bits_ff} + {3'b0, index_bits_ff};
      tag_calc = req_data.address >> sh_sum;
      set_calc = SW'(idx_raw % SETS);
   end

   wire req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != sacl_pkg::ST_IDLE);
   assign dec_fire = (state_ff == sacl_pkg::ST_DECIDE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   sacl_ram #(.WIDTH(WAYS*TW), .DEPTH(SETS)) u_tags (
      .clock(clock), .wr_en(row_we), .wr_addr(set_ff), .wr_data(tags_wr),
      .rd_addr(req_acc ? set_calc : set_ff), .rd_data(tags_rd));
   sacl_ram #(.WIDTH(WAYS*32), .DEPTH(SETS)) u_stamps (
      .clock(clock), .wr_en(row_we), .wr_addr(set_ff), .wr_data(stamps_wr),
      .rd_addr(req_acc ? set_calc : set_ff), .rd_data(stamps_rd));

   // Stage READ: register compare results and victim search.
   logic [WAYS-1:0] vrow, drow, match;
   logic hit_c, empty_c;
   logic [WW-1:0] hway_c, eway_c, oway_c;
   logic [31:0] best_st;
   always_comb begin
      hit_c = 1'b0; empty_c = 1'b0;
      hway_c = '0; eway_c = '0; oway_c = '0;
      best_st = stamps_rd[31:0];
      vrow = valid_ff[set_ff];
      for (int i = 0; i < WAYS; i++) begin
         drow[i] = tags_rd[i*TW + 32];
         match[i] = vrow[i] && (tags_rd[i*TW +: 32] == tag_ff);
      end
      for (int i = WAYS-1; i >= 0; i--) begin
         if (match[i]) begin hit_c = 1'b1; hway_c = WW'(i); end
         if (!vrow[i]) begin empty_c = 1'b1; eway_c = WW'(i); end
      end
      for (int i = 1; i < WAYS; i++) begin
         if (stamps_rd[i*32 +: 32] < best_st) begin
            best_st = stamps_rd[i*32 +: 32];
            oway_c = WW'(i);
         end
      end
   end

   logic hit_ff, empty_ff;
   logic [WW-1:0] hway_ff, eway_ff, oway_ff;
   logic [WAYS-1:0] vrow_ff, drow_ff;
   logic [WAYS*TW-1:0] trow_ff;
   logic [WAYS*32-1:0] srow_ff;

   // Stage DECIDE: pick way, write row back, update counters.
   logic [15:0] lfsr_nx;
   logic [WW-1:0] way_c;
   logic [31:0] stamp_nx;
   logic stamp_c, mrd_c, mwr_c, dset_c;
   logic [sacl_pkg::TIME_W:0] tsum;
   always_comb begin
      lfsr_nx = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};
      stamp_nx = (gstamp_ff != 32'hFFFFFFFF) ? gstamp_ff + 32'd1 : gstamp_ff;
      if (hit_ff) way_c = hway_ff;
      else if (empty_ff) way_c = eway_ff;
      else if (use_lru_ff) way_c = oway_ff;
      else way_c = WW'(32'(lfsr_nx) % WAYS);
      stamp_c = !hit_ff || use_lru_ff;
      mrd_c = !hit_ff;
      dset_c = is_wr_ff && write_back_ff;
      mwr_c = (is_wr_ff && !write_back_ff) ||
              (!hit_ff && write_back_ff && vrow_ff[way_c] && drow_ff[way_c]);
      tags_wr = trow_ff;
      stamps_wr = srow_ff;
      if (!hit_ff) tags_wr[int'(way_c)*TW +: 32] = tag_ff;
      if (!hit_ff || dset_c) tags_wr[int'(way_c)*TW + 32] = dset_c;
      if (stamp_c) stamps_wr[int'(way_c)*32 +: 32] = stamp_nx;
      row_we = dec_fire;
      tsum = {1'b0, time_ff} + (sacl_pkg::TIME_W+1)'(hit_time_ff)
           + (hit_ff ? '0 : (sacl_pkg::TIME_W+1)'(memory_time_ff));
   end

   function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
      sat_inc = (en && v != 32'hFFFFFFFF) ? v + 32'd1 : v;
   endfunction

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sacl_pkg::ST_IDLE:   if (req_acc) state_in = sacl_pkg::ST_READ;
         sacl_pkg::ST_READ:   state_in = sacl_pkg::ST_DECIDE;
         sacl_pkg::ST_DECIDE: if (dec_fire) state_in = sacl_pkg::ST_IDLE;
         default:             state_in = sacl_pkg::ST_IDLE;
      endcase
   end

   logic [31:0] c0, c1, c2, c3, c4, c5;
   logic [sacl_pkg::TIME_W-1:0] tnew;
   always_comb begin
      c0 = sat_inc(cnt_ff[0], !is_wr_ff);
      c1 = sat_inc(cnt_ff[1], is_wr_ff);
      c2 = sat_inc(cnt_ff[2], hit_ff && !is_wr_ff);
      c3 = sat_inc(cnt_ff[3], hit_ff && is_wr_ff);
      c4 = sat_inc(cnt_ff[4], mrd_c);
      c5 = sat_inc(cnt_ff[5], mwr_c);
      tnew = tsum[sacl_pkg::TIME_W] ? '1 : tsum[sacl_pkg::TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacl_pkg::ST_IDLE;
         valid_ff <= '0;
         gstamp_ff <= '0;
         lfsr_ff <= sacl_pkg::LFSR_SEED;
         for (int i = 0; i < 6; i++) cnt_ff[i] <= '0;
         time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (dec_fire) begin
            valid_ff[set_ff][way_c] <= 1'b1;
            if (stamp_c) gstamp_ff <= stamp_nx;
            if (!hit_ff && !empty_ff && !use_lru_ff) lfsr_ff <= lfsr_nx;
            cnt_ff[0] <= c0; cnt_ff[1] <= c1; cnt_ff[2] <= c2;
            cnt_ff[3] <= c3; cnt_ff[4] <= c4; cnt_ff[5] <= c5;
            time_ff <= tnew;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         tag_ff <= tag_calc;
         is_wr_ff <= req_data.req_type;
         set_ff <= set_calc;
      end
      if (state_ff == sacl_pkg::ST_READ) begin
         hit_ff <= hit_c; empty_ff <= empty_c;
         hway_ff <= hway_c; eway_ff <= eway_c; oway_ff <= oway_c;
         vrow_ff <= vrow; drow_ff <= drow;
         trow_ff <= tags_rd; srow_ff <= stamps_rd;
      end
      if (dec_fire) begin
         rsp_ff.hit <= hit_ff;
         rsp_ff.way <= 2'(way_c);
         rsp_ff.mem_read <= mrd_c;
         rsp_ff.mem_write <= mwr_c;
         rsp_ff.read_count <= c0;
         rsp_ff.write_count <= c1;
         rsp_ff.read_hit_count <= c2;
         rsp_ff.write_hit_count <= c3;
         rsp_ff.mem_read_count <= c4;
         rsp_ff.mem_write_count <= c5;
         rsp_ff.total_time <= tnew;
      end
   end
endmodule

// ===== hw/rtl/sacl_checker.sv =====
// Port-level checker for set_assoc_cache_lookup, bound to the top level.
// Uses assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sacl_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input sacl_pkg::rsp_type_type rsp_data
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CHK_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `CHK_NEXT(a_idle_after_reset, clock, 1'b0, reset, !rsp_valid && !req_stall)
   `CHK_IMPLY(a_hit_no_fetch, clock, reset, rsp_valid, rsp_data.hit != rsp_data.mem_read)
endmodule

bind set_assoc_cache_lookup sacl_port_checker u_sacl_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

// ===== tb/sacl_checker.sv =====
// Checker for the set associative cache lookup block: watches the access and result
// channels, predicts each result from its own tag, stamp and counter state, and compares.
// Depends on sacl_pkg; configuration is copied from the csr channel it observes.
`timescale 1ns / 1ps
module sacl_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  sacl_pkg::req_type_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  sacl_pkg::rsp_type_type rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_data,
   output int                     error_count,
   output int                     pending_count
);
   localparam int NSETS = 64;
   localparam int NWAYS = 4;
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

   logic [31:0] line_tag [NSETS*NWAYS];
   logic        line_valid [NSETS*NWAYS];
   logic        line_dirty [NSETS*NWAYS];
   logic [31:0] line_stamp [NSETS*NWAYS];
   logic [31:0] stamp_now;
   logic [15:0] victim_lfsr;
   logic [31:0] n_rd, n_wr, n_rdhit, n_wrhit, n_memrd, n_memwr;
   logic [47:0] time_sum;
   logic        cfg_wb, cfg_lru;
   logic [4:0]  cfg_off;
   logic [2:0]  cfg_idx;
   logic [15:0] cfg_hit_time, cfg_mem_time;

   sacl_pkg::rsp_type_type expected_results[$];

   assign pending_count = expected_results.size();

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == CNT_MAX) ? v : v + 1;
   endfunction

   function automatic logic [31:0] next_stamp();
      if (stamp_now != CNT_MAX) stamp_now = stamp_now + 1;
      return stamp_now;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic predict_access(input sacl_pkg::req_type_type a);
      sacl_pkg::rsp_type_type r;
      logic [63:0]  addr, shifted;
      logic [63:0]  mask;
      int           set, base, w, empty, best;
      logic [31:0]  tag;
      logic         hit, has_empty, mrd, mwr, wr;
      logic [48:0]  add, sum;
      addr = {32'd0, a.address};
      wr = a.req_type;
      mask = (64'd1 << cfg_idx) - 1;
      set = int'(((addr >> cfg_off) & mask) % NSETS);
      shifted = addr >> (cfg_off + cfg_idx);
      tag = shifted[31:0];
      base = set * NWAYS;
      hit = 0; has_empty = 0; w = 0; empty = 0; mrd = 0; mwr = 0;
      for (int i = 0; i < NWAYS; i++) begin
         if (!hit) begin
            if (line_valid[base+i] && line_tag[base+i] == tag) begin
               hit = 1;
               w = i;
            end else if (!line_valid[base+i] && !has_empty) begin
               has_empty = 1;
               empty = i;
            end
         end
      end
      if (hit) begin
         if (cfg_lru) line_stamp[base+w] = next_stamp();
         if (wr) begin
            if (cfg_wb) line_dirty[base+w] = 1;
            else mwr = 1;
         end
      end else begin
         if (has_empty) w = empty;
         else if (cfg_lru) begin
            best = 0;
            for (int i = 1; i < NWAYS; i++)
               if (line_stamp[base+i] < line_stamp[base+best]) best = i;
            w = best;
         end else begin
            victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                           victim_lfsr[15:1]};
            w = victim_lfsr % NWAYS;
         end
         if (cfg_wb && line_valid[base+w] && line_dirty[base+w]) mwr = 1;
         line_tag[base+w] = tag;
         line_valid[base+w] = 1;
         line_stamp[base+w] = next_stamp();
         line_dirty[base+w] = 0;
         mrd = 1;
         if (wr) begin
            if (cfg_wb) line_dirty[base+w] = 1;
            else mwr = 1;
         end
      end
      if (wr) n_wr = sat_inc(n_wr);
      else n_rd = sat_inc(n_rd);
      if (hit && wr) n_wrhit = sat_inc(n_wrhit);
      if (hit && !wr) n_rdhit = sat_inc(n_rdhit);
      if (mrd) n_memrd = sat_inc(n_memrd);
      if (mwr) n_memwr = sat_inc(n_memwr);
      add = cfg_hit_time + (hit ? 49'd0 : cfg_mem_time);
      sum = time_sum + add;
      time_sum = (sum > TIME_MAX) ? TIME_MAX : sum[47:0];
      r.hit = hit;
      r.way = w[1:0];
      r.mem_read = mrd;
      r.mem_write = mwr;
      r.read_count = n_rd;
      r.write_count = n_wr;
      r.read_hit_count = n_rdhit;
      r.write_hit_count = n_wrhit;
      r.mem_read_count = n_memrd;
      r.mem_write_count = n_memwr;
      r.total_time = time_sum;
      expected_results.push_back(r);
   endtask

   task automatic compare_result(input sacl_pkg::rsp_type_type got);
      sacl_pkg::rsp_type_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result transfer with no access outstanding", 64'd1, 64'd0);
         return;
      end
      want = expected_results.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
      if (got.way !== want.way) report_mismatch("way", got.way, want.way);
      if (got.mem_read !== want.mem_read)
         report_mismatch("mem_read", got.mem_read, want.mem_read);
      if (got.mem_write !== want.mem_write)
         report_mismatch("mem_write", got.mem_write, want.mem_write);
      if (got.read_count !== want.read_count)
         report_mismatch("read_count", got.read_count, want.read_count);
      if (got.write_count !== want.write_count)
         report_mismatch("write_count", got.write_count, want.write_count);
      if (got.read_hit_count !== want.read_hit_count)
         report_mismatch("read_hit_count", got.read_hit_count, want.read_hit_count);
      if (got.write_hit_count !== want.write_hit_count)
         report_mismatch("write_hit_count", got.write_hit_count, want.write_hit_count);
      if (got.mem_read_count !== want.mem_read_count)
         report_mismatch("mem_read_count", got.mem_read_count, want.mem_read_count);
      if (got.mem_write_count !== want.mem_write_count)
         report_mismatch("mem_write_count", got.mem_write_count, want.mem_write_count);
      if (got.total_time !== want.total_time)
         report_mismatch("total_time", got.total_time, want.total_time);
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSETS*NWAYS; i++) begin
            line_tag[i] = 0;
            line_valid[i] = 0;
            line_dirty[i] = 0;
            line_stamp[i] = 0;
         end
         stamp_now = 0;
         victim_lfsr = sacl_pkg::LFSR_SEED;
         {n_rd, n_wr, n_rdhit, n_wrhit, n_memrd, n_memwr} = '0;
         time_sum = 0;
         cfg_wb = 0; cfg_lru = 1; cfg_off = 6; cfg_idx = 6;
         cfg_hit_time = 1; cfg_mem_time = 100;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_result(rsp_data);
         if (csr_valid && csr_ready) begin
            unique case (sacl_pkg::reg_index_type'(csr_index))
               sacl_pkg::REG_WRITE_BACK:  cfg_wb = csr_data[0];
               sacl_pkg::REG_USE_LRU:     cfg_lru = csr_data[0];
               sacl_pkg::REG_OFFSET_BITS: cfg_off = csr_data[4:0];
               sacl_pkg::REG_INDEX_BITS:  cfg_idx = csr_data[2:0];
               sacl_pkg::REG_HIT_TIME:    cfg_hit_time = csr_data;
               sacl_pkg::REG_MEMORY_TIME: cfg_mem_time = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_access(req_data);
      end
   end
endmodule

// ===== tb/testbench.sv =====
// Top of the set associative cache lookup testbench: clock, reset, configuration
// phases and access stimulus with random bursts and stalls. Uses sacl_pkg, the block
// and sacl_checker, which predicts and compares every result transfer.
`timescale 1ns / 1ps
module testbench;
   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_valid = 0;
   logic                   req_stall;
   sacl_pkg::req_type_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 0;
   sacl_pkg::rsp_type_type rsp_data;
   logic                   csr_valid = 0;
   logic                   csr_ready;
   logic [2:0]             csr_index = '0;
   logic [15:0]            csr_data = '0;
   int                     error_count;
   int                     pending_count;
   int                     stall_mode = 0;
   logic [31:0]            hot_addr [16];

   set_assoc_cache_lookup dut (.*);
   sacl_checker checker_inst (.*);

   always #4 clock = ~clock;

   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic write_reg(input sacl_pkg::reg_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_access(input logic [31:0] addr, input logic kind);
      @(negedge clock);
      req_valid <= 1;
      req_data <= '{address: addr, req_type: kind};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic end_burst();
      int gap;
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic set_config(input logic wb, input logic lru, input logic [4:0] off,
                             input logic [2:0] idx, input logic [15:0] ht,
                             input logic [15:0] mt);
      write_reg(sacl_pkg::REG_WRITE_BACK, 16'(wb));
      write_reg(sacl_pkg::REG_USE_LRU, 16'(lru));
      write_reg(sacl_pkg::REG_OFFSET_BITS, 16'(off));
      write_reg(sacl_pkg::REG_INDEX_BITS, 16'(idx));
      write_reg(sacl_pkg::REG_HIT_TIME, ht);
      write_reg(sacl_pkg::REG_MEMORY_TIME, mt);
   endtask

   task automatic random_phase(input int count);
      int burst;
      logic [31:0] a;
      burst = 0;
      for (int i = 0; i < 16; i++) hot_addr[i] = $urandom;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 8) begin
            a = hot_addr[$urandom_range(0, 15)];
            a[5:0] = 6'($urandom);
         end else begin
            a = $urandom;
         end
         send_access(a, 1'($urandom_range(0, 1)));
         if (burst == 0) begin
            end_burst();
            burst = $urandom_range(1, 12);
         end else begin
            burst--;
         end
      end
      @(negedge clock);
      req_valid <= 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_access(32'h0000_0000, 0);
      send_access(32'h0000_0000, 1);
      send_access(32'hFFFF_FFFF, 1);
      send_access(32'hFFFF_FFFF, 0);
      for (int i = 1; i <= 5; i++) send_access(i << 12, 1);
      send_access(32'h0000_0000, 0);
      send_access(32'h8000_0040, 0);
      @(negedge clock);
      req_valid <= 0;
      drain();

      set_config(1, 0, 16, 6, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 8; i++) send_access((i << 22) | 32'h5A5A, i[0]);
      send_access(32'hFFFF_FFFF, 1);
      @(negedge clock);
      req_valid <= 0;
      drain();

      set_config(1, 1, 0, 0, 0, 0);
      for (int i = 0; i < 6; i++) send_access(i, 1);
      @(negedge clock);
      req_valid <= 0;
      drain();

      stall_mode = 1;
      set_config(1, 1, 6, 6, 1, 100);
      random_phase(500);
      drain();
      stall_mode = 2;
      set_config(0, 0, 4, 2, 3, 16'hFFFF);
      random_phase(500);
      drain();
      stall_mode = 0;
      set_config(1, 0, 0, 3, 16'hFFFF, 0);
      random_phase(500);
      drain();
      stall_mode = 1;
      set_config(0, 1, 16, 1, 7, 50);
      random_phase(500);
      drain();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_ram.sv
hw/rtl/set_assoc_cache_lookup.sv
hw/rtl/sacl_checker.sv
tb/sacl_checker.sv
tb/testbench.sv
